// File: rtl/core/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Concurrent assertion helpers; they compile to nothing under SYNTHESIS.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/core/tnrs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tnrs_pkg
// Shared types and constants of the point store with nearest/radius search.
// ============================================================================
package tnrs_pkg;

    // Store size and derived widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 6;
    localparam int CMP_W    = IDX_W + 1;
    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int DIST_W   = SQ_W + 1;

    // Command codes
    localparam logic [2:0] KIND_APPEND   = 3'd0;
    localparam logic [2:0] KIND_SET_FLAG = 3'd1;
    localparam logic [2:0] KIND_NEAREST  = 3'd2;
    localparam logic [2:0] KIND_RADIUS   = 3'd3;
    localparam logic [2:0] KIND_CLEAR    = 3'd4;

    // Input word
    typedef struct packed {
        logic [2:0]                 kind;
        logic [IDX_W-1:0]           entry_index;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic                       member_flag;
        logic                       only_members;
        logic [COORD_W-1:0]         radius;
    } cmd_t;

    // Result word
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   match_index;
        logic [DIST_W-1:0]  distance_sq;
        logic               last;
        logic               full_error;
    } result_t;

    // One stored point
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               flag;
    } mem_word_t;

    // Tag that travels with an entry through the distance pipeline
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] idx;
    } tag_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPEND,
        ST_SET_RD,
        ST_SET_WR,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/core/tnrs_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// tnrs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module tnrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/tnrs_dist.sv
`timescale 1ns / 1ps
// ============================================================================
// tnrs_dist
// Three-stage squared-distance pipeline: difference, squares, sum.
// ============================================================================
module tnrs_dist (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tnrs_pkg::tag_t                       point_tag,
    input  tnrs_pkg::mem_word_t                  point,
    input  logic signed [tnrs_pkg::COORD_W-1:0]  query_x,
    input  logic signed [tnrs_pkg::COORD_W-1:0]  query_y,
    output tnrs_pkg::tag_t                       sum_tag,
    output logic [tnrs_pkg::DIST_W-1:0]          dist_sq,
    output logic                                 busy
);
    import tnrs_pkg::*;

    tag_t                     tag_a_reg, tag_b_reg, tag_c_reg;
    logic signed [DIFF_W-1:0] dx_a_reg, dy_a_reg, dx_a_next, dy_a_next;
    logic [SQ_W-1:0]          sqx_b_reg, sqy_b_reg, sqx_b_next, sqy_b_next;
    logic [DIST_W-1:0]        d_c_reg, d_c_next;
    logic signed [2*DIFF_W-1:0] prod_x, prod_y;

    // Stage math
    always_comb
    begin
        dx_a_next  = $signed({point.x[COORD_W-1], point.x})
                   - $signed({query_x[COORD_W-1], query_x});
        dy_a_next  = $signed({point.y[COORD_W-1], point.y})
                   - $signed({query_y[COORD_W-1], query_y});
        prod_x     = dx_a_reg * dx_a_reg;
        prod_y     = dy_a_reg * dy_a_reg;
        // |d| <= 65535, so each square fits SQ_W bits
        sqx_b_next = prod_x[SQ_W-1:0];
        sqy_b_next = prod_y[SQ_W-1:0];
        d_c_next   = {1'b0, sqx_b_reg} + {1'b0, sqy_b_reg};
    end

    // Tags carry the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else
        begin
            tag_a_reg <= point_tag;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    // Data path registers
    always_ff @(posedge clk)
    begin
        dx_a_reg  <= dx_a_next;
        dy_a_reg  <= dy_a_next;
        sqx_b_reg <= sqx_b_next;
        sqy_b_reg <= sqy_b_next;
        d_c_reg   <= d_c_next;
    end

    assign sum_tag = tag_c_reg;
    assign dist_sq = d_c_reg;
    assign busy    = tag_a_reg.valid | tag_b_reg.valid | tag_c_reg.valid;

endmodule

// File: rtl/core/tree_nearest_and_radius_search.sv
`timescale 1ns / 1ps
// ============================================================================
// tree_nearest_and_radius_search
// Planar point store with nearest and radius search over one RAM.
// ============================================================================
// A word is taken when start is high and busy is low; results come out one
// per cycle on result, marked by strobe, and cannot be held off. Append is
// busy for 1 cycle and gives one result, strobed in the first cycle after
// busy falls. Set flag is busy for a read-modify-write of the entry when
// the entry exists and not otherwise; clear and unused codes never raise
// busy, and none of these gives a result. A nearest or radius query keeps
// busy high through its scan and closing state: the single RAM read port
// delivers one entry per cycle, the read/difference/square/sum pipeline
// follows, the sequencer sees it drained and then forms the closing result,
// which is strobed in the first cycle after busy falls. Radius matches come
// out during the scan, each delayed until the next match is known, so the
// final one carries last.
module tree_nearest_and_radius_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  tnrs_pkg::cmd_t     cmd,
    output logic               strobe,
    output tnrs_pkg::result_t  result
);
    import tnrs_pkg::*;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    tag_t               tag1_reg, issue_tag, cand_tag;
    logic [SQ_W-1:0]    r2_reg, r2_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [ADDR_W-1:0]  hold_idx_reg, hold_idx_next;
    logic [DIST_W-1:0]  hold_d_reg, hold_d_next;
    logic               strobe_reg, strobe_next;
    result_t            result_reg, result_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    mem_word_t          mem_wdata, mem_rdata;

    tag_t               dist_tag;
    logic [DIST_W-1:0]  dist_sq;
    logic               dist_busy;

    // Point store
    tnrs_ram #(
        .WIDTH ($bits(mem_word_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Candidate filter on the read data; entry 0 always counts for nearest
    always_comb
    begin
        cand_tag       = tag1_reg;
        cand_tag.valid = tag1_reg.valid
                       && (!cmd_reg.only_members || mem_rdata.flag
                           || (cmd_reg.kind == KIND_NEAREST && tag1_reg.idx == '0));
    end

    // Distance pipeline
    tnrs_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .point_tag (cand_tag),
        .point     (mem_rdata),
        .query_x   (cmd_reg.coord_x),
        .query_y   (cmd_reg.coord_y),
        .sum_tag   (dist_tag),
        .dist_sq   (dist_sq),
        .busy      (dist_busy)
    );

    // Sequencer: next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        r2_next         = r2_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        hold_d_next     = hold_d_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[ADDR_W-1:0];
        mem_wdata       = '{x: cmd_reg.coord_x, y: cmd_reg.coord_y,
                            flag: cmd_reg.member_flag};
        mem_raddr       = issue_reg[ADDR_W-1:0];
        issue_tag       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    r2_next  = SQ_W'(cmd.radius) * SQ_W'(cmd.radius);
                    unique case (cmd.kind) inside
                        KIND_APPEND:
                        begin
                            state_next = ST_APPEND;
                        end
                        KIND_SET_FLAG:
                        begin
                            if ({1'b0, cmd.entry_index} < CMP_W'(count_reg))
                            begin
                                state_next = ST_SET_RD;
                            end
                        end
                        KIND_NEAREST, KIND_RADIUS:
                        begin
                            state_next      = ST_SCAN;
                            issue_next      = '0;
                            hold_valid_next = 1'b0;
                        end
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_APPEND:
            begin
                strobe_next = 1'b1;
                result_next = '{found: 1'b0, match_index: '0, distance_sq: '0,
                                last: 1'b1, full_error: 1'b1};
                if (count_reg < CNT_W'(CAPACITY))
                begin
                    mem_we                 = 1'b1;
                    count_next             = count_reg + 1'b1;
                    result_next.full_error = 1'b0;
                end
                state_next = ST_IDLE;
            end
            ST_SET_RD:
            begin
                mem_raddr  = cmd_reg.entry_index[ADDR_W-1:0];
                state_next = ST_SET_WR;
            end
            ST_SET_WR:
            begin
                // Read data is this entry; only the flag changes
                mem_we     = 1'b1;
                mem_waddr  = cmd_reg.entry_index[ADDR_W-1:0];
                mem_wdata  = '{x: mem_rdata.x, y: mem_rdata.y,
                               flag: cmd_reg.member_flag};
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    issue_tag  = '{valid: 1'b1, idx: issue_reg[ADDR_W-1:0]};
                    issue_next = issue_reg + 1'b1;
                end
                else if (!tag1_reg.valid && !dist_busy)
                begin
                    state_next = ST_FINISH;
                end

                // Fold in the distance leaving the pipeline
                if (dist_tag.valid)
                begin
                    if (cmd_reg.kind == KIND_NEAREST)
                    begin
                        if (!hold_valid_reg || dist_sq < hold_d_reg)
                        begin
                            hold_valid_next = 1'b1;
                            hold_idx_next   = dist_tag.idx;
                            hold_d_next     = dist_sq;
                        end
                    end
                    else if (dist_sq < {1'b0, r2_reg})
                    begin
                        // Previous match is not the last one
                        if (hold_valid_reg)
                        begin
                            strobe_next = 1'b1;
                            result_next = '{found: 1'b1,
                                            match_index: IDX_W'(hold_idx_reg),
                                            distance_sq: hold_d_reg,
                                            last: 1'b0, full_error: 1'b0};
                        end
                        hold_valid_next = 1'b1;
                        hold_idx_next   = dist_tag.idx;
                        hold_d_next     = dist_sq;
                    end
                end
            end
            ST_FINISH:
            begin
                strobe_next = 1'b1;
                if (hold_valid_reg)
                begin
                    result_next = '{found: 1'b1, match_index: IDX_W'(hold_idx_reg),
                                    distance_sq: hold_d_reg,
                                    last: 1'b1, full_error: 1'b0};
                end
                else
                begin
                    result_next = '{found: 1'b0, match_index: '0, distance_sq: '0,
                                    last: 1'b1, full_error: 1'b0};
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            tag1_reg       <= '0;
            hold_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            tag1_reg       <= issue_tag;
            hold_valid_reg <= hold_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        r2_reg       <= r2_next;
        hold_idx_reg <= hold_idx_next;
        hold_d_reg   <= hold_d_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // Checks
    `include "assert_macros.svh"

    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CNT_W'(CAPACITY), "entry count past capacity")
    `ASSERT_PROP(a_read_in_scan, clk, rst_n, tag1_reg.valid |-> state_reg == ST_SCAN, "entry read outside a scan")
    `ASSERT_PROP(a_miss_is_last, clk, rst_n, (strobe && !result.found) |-> result.last, "empty result not final")
    `ASSERT_PROP(a_query_starts, clk, rst_n, (start && !busy && (cmd.kind == KIND_NEAREST || cmd.kind == KIND_RADIUS)) |=> state_reg == ST_SCAN, "query did not start a scan")

endmodule
